// File: src/bke_pkg.sv
// Package for the bijective key enumerator: sizes, op and register codes,
// and the structs passed between the front, back and seek units.
// No dependencies.
package bke_pkg;

	// Sizes
	localparam int MAX_KEY_LEN  = 8;
	localparam int ALPHABET_MAX = 64;
	localparam int OP_W         = 2;
	localparam int KEY_W        = 64;
	localparam int CHAR_IDX_W   = 6;
	localparam int CHAR_W       = 8;
	localparam int BASE_W       = $clog2(ALPHABET_MAX + 1);
	localparam int DIGIT_W      = $clog2(ALPHABET_MAX);
	localparam int LEN_W        = $clog2(MAX_KEY_LEN + 1);
	localparam int POS_W        = $clog2(MAX_KEY_LEN);
	localparam int BIT_CNT_W    = $clog2(KEY_W);
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 8;

	// Input op codes (code 3 becomes a no-op command)
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_SEEK    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// Command kinds after classification
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_NOP     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEEK    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd3;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 4'd1;
	localparam logic [BASE_W-1:0]    ALPHABET_RESET    = 7'd26;
	localparam logic [LEN_W-1:0]     MAXLEN_RESET      = 4'd8;

	typedef logic [MAX_KEY_LEN-1:0][DIGIT_W-1:0] digits_t;

	// Effective (clamped) configuration
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [LEN_W-1:0]  max_len;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]      kind;
		logic [KEY_W-1:0]      key_number;
		logic [CHAR_IDX_W-1:0] char_index;
		logic [CHAR_W-1:0]     char_code;
	} cmd_t;

	typedef struct packed {
		logic             done;
		logic             oor;
		logic [LEN_W-1:0] len;
		digits_t          digits;
	} seek_res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_chars;
		logic [LEN_W-1:0] key_length;
		logic             range_end;
		logic             out_of_range;
	} result_t;

endpackage

// File: src/bke_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bke_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/bke_front.sv
// Front end: accepts input items, classifies the op and queues commands
// for the back end in a two-entry queue. Depends on bke_pkg.
module bke_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [bke_pkg::OP_W-1:0]           op,
	input  logic [bke_pkg::KEY_W-1:0]          key_number,
	input  logic [bke_pkg::CHAR_IDX_W-1:0]     char_index,
	input  logic [bke_pkg::CHAR_W-1:0]         char_code,
	output logic                               cmd_valid,
	output bke_pkg::cmd_t                      cmd,
	input  logic                               cmd_pop
);

	bke_pkg::cmd_t slot_q [2];
	bke_pkg::cmd_t new_cmd;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          accept;
	logic          take;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign accept    = push && !full;
	assign take      = cmd_pop && cmd_valid;

	// Classify the op
	always_comb begin
		new_cmd.key_number = key_number;
		new_cmd.char_index = char_index;
		new_cmd.char_code  = char_code;
		case (op)
			bke_pkg::OP_WRITE:   new_cmd.kind = bke_pkg::CMD_WRITE;
			bke_pkg::OP_SEEK:    new_cmd.kind = bke_pkg::CMD_SEEK;
			bke_pkg::OP_ADVANCE: new_cmd.kind = bke_pkg::CMD_ADVANCE;
			default:             new_cmd.kind = bke_pkg::CMD_NOP;
		endcase
	end

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// File: src/bke_seek.sv
// Seek unit: counts the keys, finds the key length by taking off powers of
// the base, then splits the remainder into digits with a bit-serial divider.
// Depends on bke_pkg.
module bke_seek (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bke_pkg::KEY_W-1:0] key_number,
	input  bke_pkg::cfg_t             cfg,
	output bke_pkg::seek_res_t        res
);

	localparam logic [2:0] SK_IDLE = 3'd0;
	localparam logic [2:0] SK_POW  = 3'd1;
	localparam logic [2:0] SK_CHK  = 3'd2;
	localparam logic [2:0] SK_LEN  = 3'd3;
	localparam logic [2:0] SK_DIV  = 3'd4;

	logic [2:0]                               state_q;
	logic                                     done_q;
	logic                                     oor_q;
	logic                                     sat_q;
	logic [bke_pkg::LEN_W-1:0]                i_q;
	logic [bke_pkg::LEN_W-1:0]                len_q;
	logic [bke_pkg::LEN_W-1:0]                k_q;
	logic [bke_pkg::BIT_CNT_W-1:0]            bit_q;
	logic [bke_pkg::KEY_W-1:0]                n_q;
	logic [bke_pkg::KEY_W-1:0]                total_q;
	logic [bke_pkg::KEY_W-1:0]                pw_q;
	logic [bke_pkg::KEY_W-1:0]                rem_q;
	logic [bke_pkg::DIGIT_W-1:0]              r_q;
	bke_pkg::digits_t                         digits_q;

	logic [bke_pkg::KEY_W+bke_pkg::BASE_W-1:0] prod;
	logic                                      mul_ovf;
	logic [bke_pkg::KEY_W-1:0]                 pw_mul;
	logic [bke_pkg::KEY_W:0]                   sum;
	logic                                      mul_due;
	logic                                      len_go;
	logic [bke_pkg::BASE_W-1:0]                trial;
	logic                                      ge;
	logic [bke_pkg::DIGIT_W-1:0]               r_new;
	logic [bke_pkg::KEY_W-1:0]                 q_new;
	logic                                      last_bit;

	// Saturating power step and running key count
	assign prod    = {{bke_pkg::BASE_W{1'b0}}, pw_q} * {{bke_pkg::KEY_W{1'b0}}, cfg.base};
	assign mul_ovf = |prod[bke_pkg::KEY_W+bke_pkg::BASE_W-1:bke_pkg::KEY_W];
	assign pw_mul  = mul_ovf ? '1 : prod[bke_pkg::KEY_W-1:0];
	assign sum     = {1'b0, total_q} + {1'b0, pw_q};
	assign mul_due = (i_q < cfg.max_len);
	assign len_go  = (len_q < cfg.max_len) && (rem_q >= pw_q);

	// One restoring division step per cycle
	assign trial    = {r_q, rem_q[bke_pkg::KEY_W-1]};
	assign ge       = (trial >= cfg.base);
	assign r_new    = ge ? bke_pkg::DIGIT_W'(trial - cfg.base) : bke_pkg::DIGIT_W'(trial);
	assign q_new    = {rem_q[bke_pkg::KEY_W-2:0], ge};
	assign last_bit = (bit_q == '1);

	assign res.done   = done_q;
	assign res.oor    = oor_q;
	assign res.len    = len_q;
	assign res.digits = digits_q;

	// Sequence the seek phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SK_IDLE;
			done_q  <= 1'b0;
			oor_q   <= 1'b0;
			sat_q   <= 1'b0;
			i_q     <= '0;
			len_q   <= '0;
			k_q     <= '0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SK_IDLE: begin
					if (start) begin
						sat_q   <= 1'b0;
						i_q     <= '0;
						state_q <= SK_POW;
					end
				end
				SK_POW: begin
					sat_q <= sat_q | sum[bke_pkg::KEY_W] | (mul_due & mul_ovf);
					i_q   <= i_q + 1'b1;
					if (i_q == cfg.max_len) begin
						state_q <= SK_CHK;
					end
				end
				SK_CHK: begin
					if (!sat_q && (n_q >= total_q)) begin
						oor_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= SK_IDLE;
					end else begin
						oor_q   <= 1'b0;
						len_q   <= '0;
						state_q <= SK_LEN;
					end
				end
				SK_LEN: begin
					if (len_go) begin
						len_q <= len_q + 1'b1;
					end else begin
						k_q     <= '0;
						bit_q   <= '0;
						state_q <= SK_DIV;
					end
				end
				SK_DIV: begin
					if (k_q >= len_q) begin
						done_q  <= 1'b1;
						state_q <= SK_IDLE;
					end else begin
						bit_q <= bit_q + 1'b1;
						if (last_bit) begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= SK_IDLE;
			endcase
		end
	end

	// Datapath: count, powers, remainder and digits
	always_ff @(posedge clk) begin
		case (state_q)
			SK_IDLE: begin
				if (start) begin
					n_q     <= key_number;
					total_q <= '0;
					pw_q    <= bke_pkg::KEY_W'(1);
				end
			end
			SK_POW: begin
				total_q <= sum[bke_pkg::KEY_W] ? '1 : sum[bke_pkg::KEY_W-1:0];
				if (mul_due) begin
					pw_q <= pw_mul;
				end
			end
			SK_CHK: begin
				rem_q    <= n_q;
				pw_q     <= bke_pkg::KEY_W'(1);
				digits_q <= '0;
				r_q      <= '0;
			end
			SK_LEN: begin
				if (len_go) begin
					rem_q <= rem_q - pw_q;
					pw_q  <= pw_mul;
				end
			end
			SK_DIV: begin
				if (k_q < len_q) begin
					rem_q <= q_new;
					if (last_bit) begin
						digits_q[k_q[bke_pkg::POS_W-1:0]] <= r_new;
						r_q <= '0;
					end else begin
						r_q <= r_new;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: src/bke_back.sv
// Back end: executes commands (table write, seek, advance), looks up the key
// characters in banked copies of the character table and queues results.
// Depends on bke_pkg, bke_seek and bke_ram.
module bke_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bke_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	input  bke_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               pop,
	output logic               empty,
	output bke_pkg::result_t   res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEEK = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0]                   state_q;
	bke_pkg::digits_t             digit_q;
	logic [bke_pkg::LEN_W-1:0]    len_q;
	logic                         exh_q;
	logic                         end_q;
	logic                         oor_q;
	bke_pkg::result_t             out_q [2];
	logic                         out_wr_q;
	logic                         out_rd_q;
	logic [1:0]                   out_cnt_q;

	logic                         start;
	logic                         seek_start;
	logic                         tbl_wr;
	bke_pkg::seek_res_t           seek_res;
	logic [bke_pkg::DIGIT_W-1:0]  base_m1;
	bke_pkg::digits_t             adv_digits;
	logic                         carry;
	logic                         found;
	logic                         grow;
	logic [bke_pkg::CHAR_W-1:0]   rd_char [bke_pkg::MAX_KEY_LEN];
	bke_pkg::result_t             new_res;
	logic                         res_push;
	logic                         res_pop;

	assign start      = (state_q == ST_IDLE) && cmd_valid && (out_cnt_q != 2'd2);
	assign cmd_pop    = start;
	assign seek_start = start && (cmd.kind == bke_pkg::CMD_SEEK);
	assign tbl_wr     = start && (cmd.kind == bke_pkg::CMD_WRITE);
	assign base_m1    = bke_pkg::DIGIT_W'(cfg.base - 1'b1);
	assign res_push   = (state_q == ST_READ);
	assign res_pop    = pop && (out_cnt_q != 2'd0);
	assign empty      = (out_cnt_q == 2'd0);
	assign res        = out_q[out_rd_q];

	bke_seek u_seek (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (seek_start),
		.key_number (cmd.key_number),
		.cfg        (cfg),
		.res        (seek_res)
	);

	// One table copy per key position, all written together
	for (genvar g = 0; g < bke_pkg::MAX_KEY_LEN; g++) begin : g_tbl
		bke_ram #(
			.WIDTH (bke_pkg::CHAR_W),
			.DEPTH (bke_pkg::ALPHABET_MAX)
		) u_tbl (
			.clk     (clk),
			.wr_en   (tbl_wr),
			.wr_addr (cmd.char_index),
			.wr_data (cmd.char_code),
			.rd_en   (state_q == ST_LOOK),
			.rd_addr (digit_q[g]),
			.rd_data (rd_char[g])
		);
	end

	// Odometer: ripple the carry through the digits of the current length
	always_comb begin
		adv_digits = digit_q;
		carry      = 1'b1;
		found      = 1'b0;
		for (int i = 0; i < bke_pkg::MAX_KEY_LEN; i++) begin
			if ((bke_pkg::LEN_W'(i) < len_q) && carry) begin
				if (digit_q[i] >= base_m1) begin
					adv_digits[i] = '0;
				end else begin
					adv_digits[i] = bke_pkg::DIGIT_W'(digit_q[i] + 1'b1);
					carry         = 1'b0;
					found         = 1'b1;
				end
			end
		end
		grow = !found && (len_q < cfg.max_len)
			&& (len_q < bke_pkg::LEN_W'(bke_pkg::MAX_KEY_LEN));
		for (int i = 0; i < bke_pkg::MAX_KEY_LEN; i++) begin
			if (grow && (bke_pkg::LEN_W'(i) == len_q)) begin
				adv_digits[i] = '0;
			end
		end
	end

	// Pack the looked-up characters, zero above the key length
	always_comb begin
		new_res.key_length   = len_q;
		new_res.range_end    = end_q;
		new_res.out_of_range = oor_q;
		for (int k = 0; k < bke_pkg::MAX_KEY_LEN; k++) begin
			new_res.key_chars[k*bke_pkg::CHAR_W +: bke_pkg::CHAR_W] =
				(bke_pkg::LEN_W'(k) < len_q) ? rd_char[k] : '0;
		end
	end

	// Execute commands and update the key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			digit_q <= '0;
			len_q   <= '0;
			exh_q   <= 1'b0;
			end_q   <= 1'b0;
			oor_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						end_q <= 1'b0;
						oor_q <= 1'b0;
						case (cmd.kind)
							bke_pkg::CMD_SEEK: begin
								state_q <= ST_SEEK;
							end
							bke_pkg::CMD_ADVANCE: begin
								if (exh_q) begin
									end_q <= 1'b1;
								end else if (found) begin
									digit_q <= adv_digits;
								end else if (grow) begin
									digit_q <= adv_digits;
									len_q   <= len_q + 1'b1;
								end else begin
									exh_q <= 1'b1;
									end_q <= 1'b1;
								end
								state_q <= ST_LOOK;
							end
							default: begin
								state_q <= ST_LOOK;
							end
						endcase
					end
				end
				ST_SEEK: begin
					if (seek_res.done) begin
						if (seek_res.oor) begin
							oor_q <= 1'b1;
						end else begin
							digit_q <= seek_res.digits;
							len_q   <= seek_res.len;
							exh_q   <= 1'b0;
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance result queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				out_wr_q <= !out_wr_q;
			end
			if (res_pop) begin
				out_rd_q <= !out_rd_q;
			end
			case ({res_push, res_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	// Hold queued results
	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q[out_wr_q] <= new_res;
		end
	end

endmodule

// File: src/bijective_key_enumerator.sv
// Top level of the bijective key enumerator: configuration registers and the
// front and back ends. Depends on bke_pkg, bke_front and bke_back.

// Enumerates keys over a loaded character set in bijective base-k order, one
// result per input item, through two-entry queues on both sides. A table
// write, an advance or an unknown op passes through the back end in three
// steps (state update, table read, result write). A seek first runs the seek
// unit, whose bit-serial divider produces the digits of the resulting key one
// at a time. Configuration writes are taken at any time, with ready held high,
// and must only be issued while the block is idle. Characters of table entries
// never written read as undefined.
module bijective_key_enumerator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [bke_pkg::OP_W-1:0]          op,
	input  logic [bke_pkg::KEY_W-1:0]         key_number,
	input  logic [bke_pkg::CHAR_IDX_W-1:0]    char_index,
	input  logic [bke_pkg::CHAR_W-1:0]        char_code,
	output logic                              empty,
	input  logic                              pop,
	output logic [bke_pkg::KEY_W-1:0]         key_chars,
	output logic [bke_pkg::LEN_W-1:0]         key_length,
	output logic                              range_end,
	output logic                              out_of_range,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bke_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bke_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [bke_pkg::BASE_W-1:0] alphabet_size_q;
	logic [bke_pkg::LEN_W-1:0]  max_length_q;
	bke_pkg::cfg_t              cfg;
	logic                       cmd_valid;
	bke_pkg::cmd_t              cmd;
	logic                       cmd_pop;
	bke_pkg::result_t           res;

	assign cfg_ready    = 1'b1;
	assign key_chars    = res.key_chars;
	assign key_length   = res.key_length;
	assign range_end    = res.range_end;
	assign out_of_range = res.out_of_range;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_size_q <= bke_pkg::ALPHABET_RESET;
			max_length_q    <= bke_pkg::MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bke_pkg::REG_ALPHABET_SIZE: alphabet_size_q <= cfg_data[bke_pkg::BASE_W-1:0];
				bke_pkg::REG_MAX_LENGTH:    max_length_q    <= cfg_data[bke_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp base and length limit to their legal ranges
	always_comb begin
		if (alphabet_size_q == '0) begin
			cfg.base = bke_pkg::BASE_W'(1);
		end else if (alphabet_size_q > bke_pkg::BASE_W'(bke_pkg::ALPHABET_MAX)) begin
			cfg.base = bke_pkg::BASE_W'(bke_pkg::ALPHABET_MAX);
		end else begin
			cfg.base = alphabet_size_q;
		end
		if (max_length_q == '0) begin
			cfg.max_len = bke_pkg::LEN_W'(1);
		end else if (max_length_q > bke_pkg::LEN_W'(bke_pkg::MAX_KEY_LEN)) begin
			cfg.max_len = bke_pkg::LEN_W'(bke_pkg::MAX_KEY_LEN);
		end else begin
			cfg.max_len = max_length_q;
		end
	end

	bke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.key_number (key_number),
		.char_index (char_index),
		.char_code  (char_code),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	bke_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

`ifndef NO_ASSERTIONS
	// A shown key never exceeds the longest key
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(key_length) <= bke_pkg::MAX_KEY_LEN))
		else $error("key_length above maximum key length");

	// A result never flags both end of range and a bad seek
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(range_end && out_of_range))
		else $error("range_end and out_of_range both set");

	// The empty key carries no characters
	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (key_length == '0)) |-> (key_chars == '0))
		else $error("characters present on an empty key");
`endif

endmodule
